// File: src/xoshiro256_random_generator_macros.svh
// Assertion macros for the xoshiro256 generator RTL, used by xrng_ctrl.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef XOSHIRO256_RANDOM_GENERATOR_MACROS_SVH
`define XOSHIRO256_RANDOM_GENERATOR_MACROS_SVH

// same-cycle implication
`define XRNG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XRNG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/xrng_pkg.sv
// Types, constants and functions of the xoshiro256 generator.
// No dependencies; used by xrng_ctrl, xrng_dp and the top level.
package xrng_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned NumWords = 4;
  localparam int unsigned ShiftW   = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned JumpSteps = WordW * NumWords;
  localparam int unsigned JumpCntW  = $clog2(JumpSteps);

  typedef logic [NumWords-1:0][WordW-1:0] state_t;

  typedef enum logic [1:0] {
    FUNC_DRAW      = 2'd0,
    FUNC_JUMP      = 2'd1,
    FUNC_LONG_JUMP = 2'd2,
    FUNC_RESEED    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_CHECK,
    ST_JUMP,
    ST_FINISH
  } state_e;

  localparam logic [1:0] ModePlus     = 2'd0;
  localparam logic [1:0] ModePlusPlus = 2'd1;
  localparam logic [1:0] ModeStarStar = 2'd2;

  localparam logic [CfgIdxW-1:0] RegMode  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSeed0 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSeed1 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSeed2 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSeed3 = 3'd4;

  // skip polynomials, word 0 in the low bits
  localparam logic [JumpSteps-1:0] JumpShort = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
  localparam logic [JumpSteps-1:0] JumpLong = {
    64'h39109bb02acbe635, 64'h77710069854ee241,
    64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};

  typedef struct packed {
    logic                load;
    logic                reseed;
    logic                draw;
    logic                check;
    logic                jump_step;
    logic                jump_last;
    logic [JumpCntW-1:0] jump_idx;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic pass;
  } status_t;

  function automatic logic [WordW-1:0] rotl(logic [WordW-1:0] x, int unsigned k);
    return (x << k) | (x >> (WordW - k));
  endfunction

  function automatic state_t advance(state_t s);
    state_t           n;
    logic [WordW-1:0] t;
    t    = s[1] << 17;
    n    = s;
    n[2] = n[2] ^ n[0];
    n[3] = n[3] ^ n[1];
    n[1] = n[1] ^ n[2];
    n[0] = n[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = rotl(n[3], 45);
    return n;
  endfunction

  function automatic logic [WordW-1:0] scramble(state_t s, logic [1:0] mode);
    logic [WordW-1:0] r;
    unique case (mode)
      ModePlus:     r = s[0] + s[3];
      ModeStarStar: r = rotl((s[1] << 2) + s[1], 7);
      default:      r = rotl(s[0] + s[3], 23) + s[0];
    endcase
    if (mode == ModeStarStar) begin
      r = (r << 3) + r;
    end
    return r;
  endfunction

  function automatic logic [ShiftW-1:0] top_bit(logic [WordW-1:0] x);
    logic [ShiftW-1:0] k;
    k = '0;
    for (int i = 0; i < WordW; i++) begin
      if (x[i]) begin
        k = ShiftW'(i);
      end
    end
    return k;
  endfunction

  function automatic logic jump_bit(logic use_long, logic [JumpCntW-1:0] idx);
    return use_long ? JumpLong[idx] : JumpShort[idx];
  endfunction

endpackage

// File: src/xrng_ctrl.sv
// Sequencer of the xoshiro256 generator: request decode, redraw loop,
// jump step count and output handshake. Uses xrng_pkg and the macro header.
`include "xoshiro256_random_generator_macros.svh"

module xrng_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  xrng_pkg::func_e     func_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  xrng_pkg::status_t   status_i,
  output xrng_pkg::cmd_t      cmd_o
);

  localparam logic [xrng_pkg::JumpCntW-1:0] LastStep =
    xrng_pkg::JumpCntW'(xrng_pkg::JumpSteps - 1);

  xrng_pkg::state_e            state_q, state_d;
  logic [xrng_pkg::JumpCntW-1:0] cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        accept;
  logic                        out_free;

  assign req_ready_o = (state_q == xrng_pkg::ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      xrng_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            xrng_pkg::FUNC_DRAW:      state_d = xrng_pkg::ST_DRAW;
            xrng_pkg::FUNC_JUMP:      state_d = xrng_pkg::ST_JUMP;
            xrng_pkg::FUNC_LONG_JUMP: state_d = xrng_pkg::ST_JUMP;
            default:                  state_d = xrng_pkg::ST_FINISH;
          endcase
        end
      end
      xrng_pkg::ST_DRAW:   state_d = xrng_pkg::ST_CHECK;
      xrng_pkg::ST_CHECK: begin
        state_d = status_i.pass ? xrng_pkg::ST_FINISH : xrng_pkg::ST_DRAW;
      end
      xrng_pkg::ST_JUMP: begin
        if (cnt_q == LastStep) begin
          state_d = xrng_pkg::ST_FINISH;
        end
      end
      xrng_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = xrng_pkg::ST_IDLE;
        end
      end
      default: state_d = xrng_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.reseed    = accept && (func_i == xrng_pkg::FUNC_RESEED);
    cmd_o.draw      = (state_q == xrng_pkg::ST_DRAW);
    cmd_o.check     = (state_q == xrng_pkg::ST_CHECK);
    cmd_o.jump_step = (state_q == xrng_pkg::ST_JUMP);
    cmd_o.jump_last = (state_q == xrng_pkg::ST_JUMP) && (cnt_q == LastStep);
    cmd_o.jump_idx  = cnt_q;
    cmd_o.out_load  = (state_q == xrng_pkg::ST_FINISH) && out_free;
  end

  assign cnt_d = (state_q == xrng_pkg::ST_JUMP) ? cnt_q + 1'b1 : '0;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xrng_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `XRNG_ASSERT_NOW(a_cnt_idle, state_q != xrng_pkg::ST_JUMP, cnt_q == '0, "jump count left over")
  `XRNG_ASSERT_NEXT(a_draw_start, accept && func_i == xrng_pkg::FUNC_DRAW, state_q == xrng_pkg::ST_DRAW, "draw not started")
  `XRNG_ASSERT_NEXT(a_redraw, state_q == xrng_pkg::ST_CHECK && !status_i.pass, state_q == xrng_pkg::ST_DRAW, "rejected draw not retried")
  `XRNG_ASSERT_NEXT(a_hold_out, state_q == xrng_pkg::ST_FINISH && out_valid_q && !out_ready_i, state_q == xrng_pkg::ST_FINISH && out_valid_q, "result dropped while output busy")

endmodule

// File: src/xrng_dp.sv
// Datapath of the xoshiro256 generator: state, seed and mode registers,
// scrambler, bound check, jump accumulator and output register. Uses xrng_pkg.
module xrng_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [xrng_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [xrng_pkg::WordW-1:0]          cfg_data_i,
  input  xrng_pkg::func_e                     func_i,
  input  logic [xrng_pkg::WordW-1:0]          bound_i,
  input  logic                                narrow_i,
  input  xrng_pkg::cmd_t                      cmd_i,
  output xrng_pkg::status_t                   status_o,
  output logic [xrng_pkg::WordW-1:0]          value_o
);

  localparam int unsigned HalfW = xrng_pkg::WordW / 2;

  logic [1:0]                    mode_q;
  xrng_pkg::state_t              seed_q;
  xrng_pkg::state_t              gen_q, gen_d;
  xrng_pkg::state_t              acc_q, acc_d;
  logic [xrng_pkg::WordW-1:0]    bound_q;
  logic                          narrow_q;
  logic                          long_q;
  logic [xrng_pkg::WordW-1:0]    word_q;
  logic [xrng_pkg::ShiftW-1:0]   sh_q, sh_d;
  logic [xrng_pkg::WordW-1:0]    res_q;
  logic [xrng_pkg::WordW-1:0]    out_q;
  logic [xrng_pkg::WordW-1:0]    lim_draw, lim_chk, base, shifted, res_d;

  // shift for the bound's bit length, from the request registers
  assign lim_draw = narrow_q ? {{HalfW{1'b0}}, bound_q[HalfW-1:0]} : bound_q;
  assign sh_d = (narrow_q ? xrng_pkg::ShiftW'(HalfW - 1) : xrng_pkg::ShiftW'(xrng_pkg::WordW - 1))
                - xrng_pkg::top_bit(lim_draw);

  assign lim_chk  = lim_draw;
  assign base     = narrow_q ? {{HalfW{1'b0}}, word_q[HalfW-1:0]} : word_q;
  assign shifted  = base >> sh_q;
  assign status_o.pass = (lim_chk == '0) || (shifted < lim_chk);
  assign res_d    = (lim_chk == '0) ? base : shifted;
  assign value_o  = out_q;

  always_comb begin
    gen_d = gen_q;
    acc_d = acc_q;
    if (cmd_i.reseed) begin
      gen_d = xrng_pkg::advance(seed_q);
    end
    if (cmd_i.draw) begin
      gen_d = xrng_pkg::advance(gen_q);
    end
    if (cmd_i.jump_step) begin
      acc_d = xrng_pkg::jump_bit(long_q, cmd_i.jump_idx) ? (acc_q ^ gen_q) : acc_q;
      gen_d = cmd_i.jump_last ? acc_d : xrng_pkg::advance(gen_q);
    end
    if (cmd_i.load) begin
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= xrng_pkg::ModePlusPlus;
      seed_q <= xrng_pkg::state_t'(1);
      gen_q  <= xrng_pkg::state_t'(1);
    end else begin
      gen_q <= gen_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          xrng_pkg::RegMode:  mode_q    <= cfg_data_i[1:0];
          xrng_pkg::RegSeed0: seed_q[0] <= cfg_data_i;
          xrng_pkg::RegSeed1: seed_q[1] <= cfg_data_i;
          xrng_pkg::RegSeed2: seed_q[2] <= cfg_data_i;
          xrng_pkg::RegSeed3: seed_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load) begin
      bound_q  <= bound_i;
      narrow_q <= narrow_i;
      long_q   <= (func_i == xrng_pkg::FUNC_LONG_JUMP);
      res_q    <= '0;
    end
    if (cmd_i.draw) begin
      word_q <= xrng_pkg::scramble(gen_q, mode_q);
      sh_q   <= sh_d;
    end
    if (cmd_i.check && status_o.pass) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

endmodule

// File: src/xoshiro256_random_generator.sv
// Top level of the xoshiro256 generator: stream ports, config port.
// Instantiates xrng_ctrl and xrng_dp; uses xrng_pkg.
//
// One request per input beat, one result beat per request. A draw passes
// through the DRAW, CHECK and FINISH states before the next beat is taken,
// and every rejected attempt of a bounded draw repeats DRAW (scramble and
// advance the state) and CHECK (shift and compare against the bound). Jump
// and long jump step the state once per cycle over the 256 bits of the skip
// polynomial; a reseed goes straight to FINISH. The result sits in an output
// register, so a new request is taken while the last result waits. Config
// writes take effect at once and belong in idle periods only.
module xoshiro256_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [63:0] bound
  input  logic [2:0]  s_axis_tuser,  // [1:0] func, [2] narrow
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [63:0] value
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  xrng_pkg::cmd_t    cmd;
  xrng_pkg::status_t status;
  xrng_pkg::func_e   func;

  assign func = xrng_pkg::func_e'(s_axis_tuser[1:0]);

  xrng_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .func_i      (func),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  xrng_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .func_i      (func),
    .bound_i     (s_axis_tdata),
    .narrow_i    (s_axis_tuser[2]),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_o     (m_axis_tdata)
  );

endmodule

// File: verif/xrng_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the xoshiro256 generator: watches the request, result and
// config ports, predicts every result beat and compares it. Uses xrng_pkg.
module xrng_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] bound
  input  logic [2:0]  s_axis_tuser,   // [1:0] func, [2] narrow
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // [63:0] value
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef logic [3:0][63:0] words_t;

  // word 0 in the low bits
  localparam logic [255:0] SkipShort = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
  localparam logic [255:0] SkipLong = {
    64'h39109bb02acbe635, 64'h77710069854ee241,
    64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};

  words_t      gen_words;
  words_t      seed_words;
  logic [1:0]  mix_mode;
  logic [63:0] expected_values[$];
  int unsigned result_idx;

  function automatic logic [63:0] rot_l(logic [63:0] x, int unsigned k);
    return (x << k) | (x >> (64 - k));
  endfunction

  function automatic words_t step_words(words_t s);
    words_t      n;
    logic [63:0] t;
    t    = s[1] << 17;
    n[2] = s[2] ^ s[0];
    n[3] = s[3] ^ s[1];
    n[1] = s[1] ^ n[2];
    n[0] = s[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = rot_l(n[3], 45);
    return n;
  endfunction

  function automatic logic [63:0] mixed_output(words_t s, logic [1:0] mode);
    case (mode)
      xrng_pkg::ModePlus:     return s[0] + s[3];
      xrng_pkg::ModeStarStar: return rot_l(s[1] * 64'd5, 7) * 64'd9;
      default:                return rot_l(s[0] + s[3], 23) + s[0];
    endcase
  endfunction

  function automatic int unsigned msb_pos(logic [63:0] x);
    int unsigned k;
    k = 0;
    for (int i = 1; i < 64; i++) begin
      if (x[i]) k = i;
    end
    return k;
  endfunction

  task automatic next_output(output logic [63:0] r);
    r = mixed_output(gen_words, mix_mode);
    gen_words = step_words(gen_words);
  endtask

  task automatic apply_skip(logic [255:0] poly);
    words_t acc;
    acc = '0;
    for (int b = 0; b < 256; b++) begin
      if (poly[b]) acc = acc ^ gen_words;
      gen_words = step_words(gen_words);
    end
    gen_words = acc;
  endtask

  task automatic predict_value(xrng_pkg::func_e func, logic [63:0] bound, logic narrow,
                               output logic [63:0] v);
    logic [63:0] r;
    logic [63:0] lim;
    int unsigned sh;
    v = '0;
    case (func)
      xrng_pkg::FUNC_DRAW: begin
        lim = narrow ? {32'd0, bound[31:0]} : bound;
        if (lim == '0) begin
          next_output(r);
          v = narrow ? {32'd0, r[31:0]} : r;
        end else begin
          sh = (narrow ? 31 : 63) - msb_pos(lim);
          do begin
            next_output(r);
            if (narrow) r = {32'd0, r[31:0]};
            r = r >> sh;
          end while (r >= lim);
          v = r;
        end
      end
      xrng_pkg::FUNC_JUMP:      apply_skip(SkipShort);
      xrng_pkg::FUNC_LONG_JUMP: apply_skip(SkipLong);
      default:                  gen_words = step_words(seed_words);
    endcase
  endtask

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    $display("ERROR result beat %0d: %s, want %h, got %h", result_idx, what, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [63:0] want;
    if (!rst_ni) begin
      gen_words  = {64'd0, 64'd0, 64'd0, 64'd1};
      seed_words = {64'd0, 64'd0, 64'd0, 64'd1};
      mix_mode   = xrng_pkg::ModePlusPlus;
      expected_values.delete();
      result_idx   = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          xrng_pkg::RegMode:  mix_mode      = cfg_data_i[1:0];
          xrng_pkg::RegSeed0: seed_words[0] = cfg_data_i;
          xrng_pkg::RegSeed1: seed_words[1] = cfg_data_i;
          xrng_pkg::RegSeed2: seed_words[2] = cfg_data_i;
          xrng_pkg::RegSeed3: seed_words[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_values.size() == 0) begin
          report("result with no request pending", '0, m_axis_tdata);
        end else begin
          want = expected_values.pop_front();
          if (m_axis_tdata !== want) report("value", want, m_axis_tdata);
        end
        result_idx++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_value(xrng_pkg::func_e'(s_axis_tuser[1:0]), s_axis_tdata,
                      s_axis_tuser[2], want);
        expected_values.push_back(want);
      end
      pending_o = expected_values.size();
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Top of the xoshiro256 generator testbench: clock, reset, request and
// config stimulus, result back-pressure and the verdict.
// Needs xrng_pkg, the generator RTL and xrng_checker.
module tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 190;
  localparam logic [1:0]  ModeSpare  = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  bit          calm = 1'b0;

  xoshiro256_random_generator i_dut (.*);

  xrng_checker i_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_req(xrng_pkg::func_e func, logic [63:0] bound, logic narrow);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bound;
    s_axis_tuser  <= {narrow, func};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_settings(logic [1:0] mode, logic [63:0] w0, logic [63:0] w1,
                               logic [63:0] w2, logic [63:0] w3);
    logic [2:0]  idx[5];
    logic [63:0] data[5];
    idx  = '{xrng_pkg::RegMode, xrng_pkg::RegSeed0, xrng_pkg::RegSeed1,
             xrng_pkg::RegSeed2, xrng_pkg::RegSeed3};
    data = '{{62'd0, mode}, w0, w1, w2, w3};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] random_bound();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = 64'd1;
      2:       v = '1;
      3:       v = 64'd1 << $urandom_range(0, 63);
      4, 5:    v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  function automatic xrng_pkg::func_e random_func();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 88) return xrng_pkg::FUNC_DRAW;
    if (pick < 93) return xrng_pkg::FUNC_RESEED;
    if (pick < 97) return xrng_pkg::FUNC_JUMP;
    return xrng_pkg::FUNC_LONG_JUMP;
  endfunction

  initial begin : result_sink
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    logic [1:0] mode;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    send_req(xrng_pkg::FUNC_DRAW, '0, 1'b0);
    send_req(xrng_pkg::FUNC_DRAW, '0, 1'b1);
    send_req(xrng_pkg::FUNC_DRAW, 64'd1, 1'b0);
    send_req(xrng_pkg::FUNC_DRAW, 64'd1, 1'b1);
    send_req(xrng_pkg::FUNC_DRAW, '1, 1'b0);
    send_req(xrng_pkg::FUNC_DRAW, 64'hffff_ffff, 1'b1);
    send_req(xrng_pkg::FUNC_DRAW, 64'h8000_0000_0000_0000, 1'b0);
    send_req(xrng_pkg::FUNC_DRAW, 64'h8000_0000, 1'b1);
    send_req(xrng_pkg::FUNC_DRAW, 64'hffff_ffff_0000_0000, 1'b1);  // upper bound bits only
    send_req(xrng_pkg::FUNC_DRAW, 64'h0000_0001_0000_0005, 1'b1);
    send_req(xrng_pkg::FUNC_DRAW, 64'd3, 1'b0);
    send_req(xrng_pkg::FUNC_JUMP, '1, 1'b1);
    send_req(xrng_pkg::FUNC_DRAW, '0, 1'b0);
    send_req(xrng_pkg::FUNC_LONG_JUMP, '0, 1'b0);
    send_req(xrng_pkg::FUNC_DRAW, 64'd1000, 1'b0);
    send_req(xrng_pkg::FUNC_RESEED, '0, 1'b0);
    send_req(xrng_pkg::FUNC_DRAW, '0, 1'b0);
    drain();

    // zero state, spare scrambler code
    load_settings(ModeSpare, '0, '0, '0, '0);
    send_req(xrng_pkg::FUNC_RESEED, '0, 1'b0);
    send_req(xrng_pkg::FUNC_DRAW, '0, 1'b0);
    send_req(xrng_pkg::FUNC_DRAW, 64'd5, 1'b0);
    send_req(xrng_pkg::FUNC_DRAW, 64'd7, 1'b1);
    send_req(xrng_pkg::FUNC_JUMP, '0, 1'b0);
    send_req(xrng_pkg::FUNC_DRAW, '0, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0:       mode = xrng_pkg::ModePlus;
        1:       mode = xrng_pkg::ModeStarStar;
        2:       mode = ModeSpare;
        default: mode = xrng_pkg::ModePlusPlus;
      endcase
      if (p == 0) begin
        load_settings(mode, '1, '1, '1, '1);
      end else if (p == 3) begin
        load_settings(mode, 64'd1, '0, '0, '0);
      end else begin
        load_settings(mode, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
      end
      calm = (p % 3 == 1);
      if (p == 2 || p == 5) hold_cycles = 300;
      send_req(xrng_pkg::FUNC_RESEED, '0, 1'b0);
      repeat (PhaseItems) begin
        send_req(random_func(), random_bound(), 1'($urandom_range(0, 1)));
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
